>>> hdl/chs_pkg.sv
package chs_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_IS_48K  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_INC   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_MOD    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FDF_48K      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FDF_44K      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_EOH   = 3'd6;

    localparam logic        ACTION_PRODUCE = 1'b0;
    localparam logic        ACTION_RESYNC  = 1'b1;

    localparam logic [7:0]  BLOCK_SIZE_VALUE = 8'd2;
    localparam logic [15:0] NO_DATA_STAMP    = 16'hFFFF;

    // one result transaction before packing
    typedef struct packed {
        logic [3:0]  count_step;
        logic [7:0]  block_count;
        logic [15:0] timestamp;
        logic [7:0]  format_dependent;
        logic [7:0]  format_eoh;
        logic [7:0]  block_size;
        logic [5:0]  source_id;
    } header_t;

    // phase mod 13 is 4, 8 or 12; quotient by reciprocal 79/1024, exact for 8 bits
    function automatic logic phase_bump(input logic [7:0] phase);
        logic [15:0] prod;
        logic [7:0]  quot;
        logic [7:0]  rem;
        begin
            prod = 16'(phase) * 16'd79;
            quot = 8'(prod >> 10);
            rem  = phase - 8'(quot * 8'd13);
            return (rem != 8'd0) && (rem[1:0] == 2'd0);
        end
    endfunction

endpackage

>>> hdl/cip_header_sequencer_top.sv
// Blocking-mode isochronous audio header generator. Each produce transaction on the
// input stream gives one header on the output stream; a resync transaction loads the
// block count and the previous-NO-DATA flag and gives nothing. One transaction per
// clock is sustained while the output is not stalled: an input register and a result
// register hold one item each, and the header arithmetic (a 13-bit add or subtract, a
// small phase compare) sits between them. A header passes through the input register
// and then the result register before it is offered on the output. Input ready follows
// output ready when both stages are full and the input stage holds a produce transaction.
// Configuration writes are taken at any time but must only be made while idle.
module cip_header_sequencer_top
    import chs_pkg::*;
#(
    parameter int unsigned TICKS_IN_CYCLE   = 3072,
    parameter int unsigned BLOCKS_IN_PACKET = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] resync_dbc, [8] resync_prev_no_data, [15:9] zero
    input  logic [15:0]            s_tdata,
    // [0] action
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [5:0] source_id, [13:6] block_size, [21:14] format_eoh,
    // [29:22] format_dependent, [45:30] timestamp, [53:46] block_count,
    // [57:54] count_step, [63:58] zero
    output logic [63:0]            m_tdata,
    // [0] no_data
    output logic                   m_tuser
);

    localparam logic [12:0] TICKS = 13'(TICKS_IN_CYCLE);
    localparam logic [7:0]  BLK8  = 8'(BLOCKS_IN_PACKET);
    localparam logic [3:0]  BLK4  = 4'(BLOCKS_IN_PACKET);

    // configuration
    logic [5:0]  node_id_reg;
    logic        rate_is_48k_reg;
    logic [11:0] offset_inc_reg;
    logic [7:0]  phase_mod_reg;
    logic [7:0]  fdf_48k_reg;
    logic [7:0]  fdf_44k_reg;
    logic [7:0]  format_eoh_reg;

    // sequencing state
    logic [7:0]  block_counter_reg, block_counter_next;
    logic        last_empty_reg, last_empty_next;
    logic [2:0]  phase_48k_reg, phase_48k_next;
    logic [12:0] stamp_offset_reg, stamp_offset_next;
    logic [7:0]  stamp_phase_reg, stamp_phase_next;

    // input stage
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [7:0]  s1_dbc_reg;
    logic        s1_prev_reg;

    // result stage
    logic        out_valid_reg;
    header_t     out_hdr_reg, out_hdr_next;
    logic        out_no_data_reg;

    logic        out_free;
    logic        s1_fire;
    logic        produce_fire;
    logic        in_fire;
    logic        empty;
    logic        empty_44k;
    logic        last_phase;
    logic [12:0] inc;
    logic [8:0]  phase_plus;

    assign out_free     = !out_valid_reg || m_tready;
    assign s1_fire      = s1_valid_reg && ((s1_action_reg == ACTION_RESYNC) || out_free);
    assign produce_fire = s1_fire && (s1_action_reg == ACTION_PRODUCE);
    assign s_tready     = !s1_valid_reg || s1_fire;
    assign in_fire      = s_tvalid && s_tready;

    always_comb
    begin
        empty_44k  = stamp_offset_reg >= TICKS;
        last_phase = (phase_mod_reg != 8'd0) && (stamp_phase_reg == phase_mod_reg - 8'd1);
        inc        = 13'(offset_inc_reg) + 13'(phase_bump(stamp_phase_reg) || last_phase);
        phase_plus = 9'(stamp_phase_reg) + 9'd1;

        block_counter_next = block_counter_reg;
        last_empty_next    = last_empty_reg;
        phase_48k_next     = phase_48k_reg;
        stamp_offset_next  = stamp_offset_reg;
        stamp_phase_next   = stamp_phase_reg;

        if (rate_is_48k_reg)
        begin
            empty          = (phase_48k_reg == 3'd7);
            phase_48k_next = phase_48k_reg + 3'd1;
        end
        else
        begin
            empty = empty_44k;
            if (empty_44k)
            begin
                stamp_offset_next = stamp_offset_reg - TICKS;
            end
            else
            begin
                stamp_offset_next = stamp_offset_reg + inc;
            end
            if (phase_plus >= 9'(phase_mod_reg))
            begin
                stamp_phase_next = 8'd0;
            end
            else
            begin
                stamp_phase_next = phase_plus[7:0];
            end
        end

        out_hdr_next.source_id        = node_id_reg;
        out_hdr_next.block_size       = BLOCK_SIZE_VALUE;
        out_hdr_next.format_eoh       = format_eoh_reg;
        out_hdr_next.format_dependent = rate_is_48k_reg ? fdf_48k_reg : fdf_44k_reg;
        out_hdr_next.block_count      = block_counter_reg;

        if (empty)
        begin
            out_hdr_next.timestamp  = NO_DATA_STAMP;
            out_hdr_next.count_step = BLK4;
            last_empty_next         = 1'b1;
        end
        else
        begin
            out_hdr_next.timestamp  = 16'(stamp_offset_next);
            out_hdr_next.count_step = last_empty_reg ? 4'd0 : BLK4;
            block_counter_next      = block_counter_reg + BLK8;
            last_empty_next         = 1'b0;
        end

        // resync overrides count and flag, touches nothing else
        if (s1_action_reg == ACTION_RESYNC)
        begin
            block_counter_next = s1_dbc_reg;
            last_empty_next    = s1_prev_reg;
            phase_48k_next     = phase_48k_reg;
            stamp_offset_next  = stamp_offset_reg;
            stamp_phase_next   = stamp_phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg       <= 6'd0;
            rate_is_48k_reg   <= 1'b1;
            offset_inc_reg    <= 12'd1386;
            phase_mod_reg     <= 8'd147;
            fdf_48k_reg       <= 8'd2;
            fdf_44k_reg       <= 8'd1;
            format_eoh_reg    <= 8'd144;
            block_counter_reg <= 8'd0;
            last_empty_reg    <= 1'b0;
            phase_48k_reg     <= 3'd0;
            stamp_offset_reg  <= 13'd0;
            stamp_phase_reg   <= 8'd0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_NODE_ID:     node_id_reg     <= cfg_data[5:0];
                    CFG_RATE_IS_48K: rate_is_48k_reg <= cfg_data[0];
                    CFG_OFFSET_INC:  offset_inc_reg  <= cfg_data;
                    CFG_PHASE_MOD:   phase_mod_reg   <= cfg_data[7:0];
                    CFG_FDF_48K:     fdf_48k_reg     <= cfg_data[7:0];
                    CFG_FDF_44K:     fdf_44k_reg     <= cfg_data[7:0];
                    CFG_FORMAT_EOH:  format_eoh_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (s1_fire)
            begin
                block_counter_reg <= block_counter_next;
                last_empty_reg    <= last_empty_next;
                phase_48k_reg     <= phase_48k_next;
                stamp_offset_reg  <= stamp_offset_next;
                stamp_phase_reg   <= stamp_phase_next;
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (produce_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg <= s_tuser;
            s1_dbc_reg    <= s_tdata[7:0];
            s1_prev_reg   <= s_tdata[8];
        end
        if (produce_fire)
        begin
            out_hdr_reg     <= out_hdr_next;
            out_no_data_reg <= empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_hdr_reg};
    assign m_tuser  = out_no_data_reg;

`ifndef SYNTHESIS
    // 48 kHz headers leave the 44.1 kHz offset and phase alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (produce_fire && rate_is_48k_reg) |=>
            ($stable(stamp_offset_reg) && $stable(stamp_phase_reg)))
        else $error("44.1 kHz state moved on a 48 kHz header");

    // a resync transaction never makes a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_action_reg == ACTION_RESYNC)) |=>
            (out_valid_reg == $past(out_valid_reg && !m_tready)))
        else $error("resync produced a result");

    // a data header advances the block count by one packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (produce_fire && !empty) |=>
            (block_counter_reg == $past(block_counter_reg + BLK8)))
        else $error("block count did not advance on data header");
`endif

endmodule
